@@ rtl/periodic_alarm_table_defines.svh @@
// ---------------------------------------------------------------------------
// periodic_alarm_table assertion macros
// Shared property wrappers for the alarm table checks.
// ---------------------------------------------------------------------------
`ifndef PERIODIC_ALARM_TABLE_DEFINES_SVH
`define PERIODIC_ALARM_TABLE_DEFINES_SVH

// implication checked every clock, quiet in reset
`define PAT_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication
`define PAT_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

@@ rtl/pat_pkg.sv @@
// ---------------------------------------------------------------------------
// pat_pkg
// Types and constants of the periodic alarm table.
// ---------------------------------------------------------------------------
`default_nettype none
package pat_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int MAX_RES = 16;
  localparam logic [15:0] STEP_RESET = 16'd100;

  localparam logic [1:0] MODE_TICK = 2'd0;
  localparam logic [1:0] MODE_REG = 2'd1;
  localparam logic [1:0] MODE_REM = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [15:0] alarm_id;
    logic signed [31:0] period;
    logic signed [31:0] first_call;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic fired;
    logic [15:0] fired_id;
    logic last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture input item
    logic tick_adv;   // now += step
    logic scan_clr;   // scan index to 0
    logic scan_step;  // process slot at scan index, advance
    logic rnd_start;  // begin rounding
    logic rnd_step;   // one restoring step
    logic reg_write;  // write rounded alarm to free slot
    logic rem_clear;  // clear matching slots
  } pat_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_hit;   // slot at scan index is due
    logic scan_end;   // at last slot
    logic rnd_done;
    logic bad;
    logic full;
    logic found;
    logic [1:0] mode;
  } pat_sts_t;
endpackage
`default_nettype wire

@@ rtl/periodic_alarm_table.sv @@
// Work per item: a tick scans the slots up to the firing cap and may wait on
//   out_stall, a register runs 31 rounding steps, remove or refused goes to the result.
// Throughput: one item at a time; the next item is taken once the last
//   result item has been loaded into the output register.
// Reset: synchronous active-low rst_n clears slots, time and control;
//   the tick step returns to 100.
// ---------------------------------------------------------------------------
// periodic_alarm_table
// Table of periodic alarms fired by a tick; controller plus datapath.
// ---------------------------------------------------------------------------
`default_nettype none
`include "periodic_alarm_table_defines.svh"
module periodic_alarm_table #(
  parameter int SLOTS = pat_pkg::SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire pat_pkg::in_item_t in_item,
  output logic out_valid,
  input  wire logic out_stall,
  output pat_pkg::out_item_t out_item
);
  pat_pkg::pat_cmd_t cmd;
  pat_pkg::pat_sts_t sts;
  logic [15:0] hit_id;

  // datapath: slots, time, scan pointer and the serial rounder
  pat_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk, .rst_n, .cfg_we, .cfg_wdata, .in_item, .cmd, .sts, .hit_id
  );

  // controller: sequences each item and owns the result register
  pat_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_item,
    .cmd, .sts, .hit_id
  );

  `PAT_ASSERT_IMP(a_busy_no_take, cmd.load, !in_stall, "load while busy")
  `PAT_ASSERT_IMP(a_wr_clean, cmd.reg_write, !sts.bad && !sts.full, "bad slot write")
  `PAT_ASSERT_IMP(a_nofire_id, out_valid && !out_item.fired, out_item.fired_id == 16'd0,
                  "id without firing")
  `PAT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item),
                  "result changed while stalled")
endmodule
`default_nettype wire

@@ rtl/pat_datapath.sv @@
// ---------------------------------------------------------------------------
// pat_datapath
// Slot storage, time counter, slot scan and bit-serial rounding unit.
// ---------------------------------------------------------------------------
`default_nettype none
module pat_datapath #(
  parameter int SLOTS = pat_pkg::SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire pat_pkg::in_item_t in_item,
  input  wire pat_pkg::pat_cmd_t cmd,
  output pat_pkg::pat_sts_t sts,
  output logic [15:0] hit_id
);
  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [15:0] step_r;
  logic [47:0] now_r;
  logic [15:0] sid_r [SLOTS];
  logic [31:0] sper_r [SLOTS];
  logic [31:0] sfst_r [SLOTS];
  logic [47:0] sdue_r [SLOTS];
  pat_pkg::in_item_t it_r;
  logic [IW-1:0] idx_r;
  // rounding: period and first call shift registers, 31 bits each; remainders 17 bits
  logic [30:0] qp_r, qf_r;
  logic [16:0] rp_r, rf_r;
  logic [4:0] rcnt_r;
  logic rbusy_r;

  logic [IW-1:0] free_idx;
  logic any_free, found;
  logic [SLOTS-1:0] match;
  logic [31:0] per_rnd, fst_rnd;
  logic [17:0] rp_try, rf_try;

  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (sid_r[i] == 16'd0) begin
        free_idx = IW'(i);
        any_free = 1'b1;
      end
    end
    // a negative request never equals a stored value, even one at or above 2^31
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = (it_r.alarm_id != 16'd0) && (sid_r[i] == it_r.alarm_id) &&
                 !it_r.period[31] && !it_r.first_call[31] &&
                 (sper_r[i] == $unsigned(it_r.period)) &&
                 (sfst_r[i] == $unsigned(it_r.first_call));
    end
    found = |match;
  end

  // one restoring division step per cycle on both values
  assign rp_try = {rp_r, qp_r[30]} - {2'b0, step_r};
  assign rf_try = {rf_r, qf_r[30]} - {2'b0, step_r};

  function automatic logic [31:0] finish(input logic [30:0] v, input logic [16:0] r,
                                         input logic [15:0] s);
    logic [31:0] res;
    if ({1'b0, v} < {16'd0, s}) res = '0;
    else if (r == 17'd0) res = {1'b0, v};
    else res = {1'b0, v} - {15'd0, r} + {16'd0, s};
    return res;
  endfunction

  assign per_rnd = finish(it_r.period[30:0], rp_r, step_r);
  assign fst_rnd = finish(it_r.first_call[30:0], rf_r, step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= pat_pkg::STEP_RESET;
      now_r <= '0;
      rbusy_r <= 1'b0;
      rcnt_r <= '0;
      idx_r <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        sid_r[i] <= '0;
        sper_r[i] <= '0;
        sfst_r[i] <= '0;
        sdue_r[i] <= '0;
      end
    end else begin
      if (cfg_we) step_r <= (cfg_wdata == 16'd0) ? 16'd1 : cfg_wdata;
      if (cmd.load) it_r <= in_item;
      if (cmd.tick_adv) now_r <= now_r + {32'd0, step_r};
      if (cmd.scan_clr) idx_r <= '0;
      if (cmd.scan_step) begin
        if (sts.scan_hit) sdue_r[idx_r] <= sdue_r[idx_r] + {16'd0, sper_r[idx_r]};
        if (!sts.scan_end) idx_r <= idx_r + 1'b1;
      end
      if (cmd.rnd_start) begin
        qp_r <= it_r.period[30:0];
        qf_r <= it_r.first_call[30:0];
        rp_r <= '0;
        rf_r <= '0;
        rcnt_r <= '0;
        rbusy_r <= 1'b1;
      end else if (cmd.rnd_step && rbusy_r) begin
        qp_r <= {qp_r[29:0], 1'b0};
        qf_r <= {qf_r[29:0], 1'b0};
        rp_r <= rp_try[17] ? {rp_r[15:0], qp_r[30]} : rp_try[16:0];
        rf_r <= rf_try[17] ? {rf_r[15:0], qf_r[30]} : rf_try[16:0];
        rcnt_r <= rcnt_r + 5'd1;
        if (rcnt_r == 5'd30) rbusy_r <= 1'b0;
      end
      if (cmd.reg_write) begin
        sid_r[free_idx] <= it_r.alarm_id;
        sper_r[free_idx] <= per_rnd;
        sfst_r[free_idx] <= fst_rnd;
        sdue_r[free_idx] <= {16'd0, fst_rnd} + {16'd0, per_rnd};
      end
      if (cmd.rem_clear) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (match[i]) begin
            sid_r[i] <= '0;
            sper_r[i] <= '0;
            sfst_r[i] <= '0;
            sdue_r[i] <= '0;
          end
        end
      end
    end
  end

  always_comb begin
    sts.scan_hit = (sid_r[idx_r] != 16'd0) && (now_r >= sdue_r[idx_r]);
    sts.scan_end = (idx_r == IW'(SLOTS - 1));
    sts.rnd_done = !rbusy_r;
    sts.bad = (it_r.alarm_id == 16'd0) || it_r.period[31] || it_r.first_call[31];
    sts.full = !any_free;
    sts.found = found;
    sts.mode = it_r.mode;
    hit_id = sid_r[idx_r];
  end
endmodule
`default_nettype wire

@@ rtl/pat_ctrl.sv @@
// ---------------------------------------------------------------------------
// pat_ctrl
// Sequencer for tick scan, register rounding and remove.
// ---------------------------------------------------------------------------
`default_nettype none
module pat_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  output pat_pkg::out_item_t out_item,
  output pat_pkg::pat_cmd_t cmd,
  input  wire pat_pkg::pat_sts_t sts,
  input  wire logic [15:0] hit_id
);
  typedef enum logic [2:0] {S_IDLE, S_DISP, S_SCAN, S_RND, S_RWR, S_DONE} state_t;

  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;
  pat_pkg::out_item_t oi_r, oi_nxt;
  // final result of the item when no firing is pending
  pat_pkg::out_item_t fin_r, fin_nxt;
  logic [4:0] nfire_r, nfire_nxt;
  // fired result held back until we know whether it is the last
  logic pend_r, pend_nxt;
  logic [15:0] pid_r, pid_nxt;

  logic out_free;
  assign out_free = !ov_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_item = oi_r;

  always_comb begin
    state_nxt = state_r;
    ov_nxt = ov_r && out_stall;
    oi_nxt = oi_r;
    fin_nxt = fin_r;
    nfire_nxt = nfire_r;
    pend_nxt = pend_r;
    pid_nxt = pid_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (sts.mode)
          pat_pkg::MODE_TICK: begin
            cmd.tick_adv = 1'b1;
            cmd.scan_clr = 1'b1;
            nfire_nxt = '0;
            pend_nxt = 1'b0;
            fin_nxt = '{pat_pkg::ST_OK, 1'b0, 16'd0, 1'b1};
            state_nxt = S_SCAN;
          end
          pat_pkg::MODE_REG: begin
            if (sts.bad) begin
              fin_nxt = '{pat_pkg::ST_BAD, 1'b0, 16'd0, 1'b1};
              state_nxt = S_DONE;
            end else if (sts.full) begin
              fin_nxt = '{pat_pkg::ST_FULL, 1'b0, 16'd0, 1'b1};
              state_nxt = S_DONE;
            end else begin
              cmd.rnd_start = 1'b1;
              state_nxt = S_RND;
            end
          end
          pat_pkg::MODE_REM: begin
            cmd.rem_clear = 1'b1;
            fin_nxt = '{sts.found ? pat_pkg::ST_OK : pat_pkg::ST_NOTFOUND,
                        1'b0, 16'd0, 1'b1};
            state_nxt = S_DONE;
          end
          default: begin
            fin_nxt = '{pat_pkg::ST_BAD, 1'b0, 16'd0, 1'b1};
            state_nxt = S_DONE;
          end
        endcase
      end
      S_SCAN: begin
        if (nfire_r == 5'(pat_pkg::MAX_RES)) begin
          // firing cap reached, later due alarms wait for the next tick
          state_nxt = S_DONE;
        end else if (!(sts.scan_hit && pend_r) || out_free) begin
          // a hit with a pending result needs the output register first
          cmd.scan_step = 1'b1;
          if (sts.scan_hit) begin
            if (pend_r) begin
              ov_nxt = 1'b1;
              oi_nxt = '{pat_pkg::ST_OK, 1'b1, pid_r, 1'b0};
            end
            pend_nxt = 1'b1;
            pid_nxt = hit_id;
            nfire_nxt = nfire_r + 5'd1;
          end
          if (sts.scan_end) state_nxt = S_DONE;
        end
      end
      S_RND: begin
        cmd.rnd_step = 1'b1;
        if (sts.rnd_done) state_nxt = S_RWR;
      end
      S_RWR: begin
        cmd.reg_write = 1'b1;
        fin_nxt = '{pat_pkg::ST_OK, 1'b0, 16'd0, 1'b1};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ov_nxt = 1'b1;
          if (pend_r) oi_nxt = '{pat_pkg::ST_OK, 1'b1, pid_r, 1'b1};
          else oi_nxt = fin_r;
          pend_nxt = 1'b0;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      oi_r <= '0;
      fin_r <= '0;
      nfire_r <= '0;
      pend_r <= 1'b0;
      pid_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      oi_r <= oi_nxt;
      fin_r <= fin_nxt;
      nfire_r <= nfire_nxt;
      pend_r <= pend_nxt;
      pid_r <= pid_nxt;
    end
  end
endmodule
`default_nettype wire

@@ sim/periodic_alarm_table_test.sv @@
// ---------------------------------------------------------------------------
// periodic_alarm_table_test
// Drives ticks, alarm registrations and removals through the table and checks
// every result item against an in-bench alarm table predictor.
// ---------------------------------------------------------------------------
`default_nettype none
module periodic_alarm_table_test;
  localparam int NSLOT = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  pat_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pat_pkg::out_item_t out_item;

  periodic_alarm_table u_top (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] step;
  logic [15:0] a_id [NSLOT];
  logic [31:0] a_per [NSLOT];
  logic [31:0] a_first [NSLOT];
  logic [47:0] a_due [NSLOT];
  logic [47:0] now_t;

  pat_pkg::out_item_t expected_q[$];
  int errors = 0;
  int idle_cycles = 0;
  bit hold_long = 1'b0;  // receiver long hold-off request

  function automatic logic [31:0] round_step(logic [31:0] v);
    logic [31:0] r;
    if (v < step) return '0;
    r = v % step;
    return (r != 0) ? v - r + step : v;
  endfunction

  // apply one input item to the predicted table and queue its results
  task automatic predict_item(pat_pkg::in_item_t it);
    int n;
    int fs;
    bit hit;
    pat_pkg::out_item_t r;
    n = 0;
    fs = -1;
    hit = 1'b0;
    r = '0;
    r.last = 1'b1;
    case (it.mode)
      pat_pkg::MODE_TICK: begin
        now_t = now_t + step;
        for (int i = 0; i < NSLOT; i++) begin
          if (n < pat_pkg::MAX_RES && a_id[i] != 0 && now_t >= a_due[i]) begin
            a_due[i] = a_due[i] + a_per[i];
            expected_q.push_back('{status: pat_pkg::ST_OK, fired: 1'b1,
                                   fired_id: a_id[i], last: 1'b0});
            n++;
          end
        end
        if (n == 0) expected_q.push_back(r);
        else expected_q[$].last = 1'b1;
      end
      pat_pkg::MODE_REG: begin
        if (it.alarm_id == 0 || it.period < 0 || it.first_call < 0) begin
          r.status = pat_pkg::ST_BAD;
        end else begin
          for (int i = NSLOT - 1; i >= 0; i--) if (a_id[i] == 0) fs = i;
          if (fs < 0) begin
            r.status = pat_pkg::ST_FULL;
          end else begin
            a_id[fs] = it.alarm_id;
            a_per[fs] = round_step(it.period);
            a_first[fs] = round_step(it.first_call);
            a_due[fs] = {16'd0, a_first[fs]} + {16'd0, a_per[fs]};
          end
        end
        expected_q.push_back(r);
      end
      pat_pkg::MODE_REM: begin
        // negative request values never match a stored alarm
        for (int i = 0; i < NSLOT; i++) begin
          if (it.alarm_id != 0 && a_id[i] == it.alarm_id && !it.period[31] &&
              !it.first_call[31] && a_per[i] == $unsigned(it.period) &&
              a_first[i] == $unsigned(it.first_call)) begin
            a_id[i] = '0; a_per[i] = '0; a_first[i] = '0; a_due[i] = '0;
            hit = 1'b1;
          end
        end
        r.status = hit ? pat_pkg::ST_OK : pat_pkg::ST_NOTFOUND;
        expected_q.push_back(r);
      end
      default: begin
        r.status = pat_pkg::ST_BAD;
        expected_q.push_back(r);
      end
    endcase
  endtask

  // result checking at the accepting edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result item status=%0d id=%0d", out_item.status,
               out_item.fired_id);
        errors++;
      end else begin
        pat_pkg::out_item_t e;
        e = expected_q.pop_front();
        if (out_item.status !== e.status) begin
          $error("status: expected %0d got %0d", e.status, out_item.status);
          errors++;
        end
        if (out_item.fired !== e.fired) begin
          $error("fired: expected %0d got %0d", e.fired, out_item.fired);
          errors++;
        end
        if (out_item.fired_id !== e.fired_id) begin
          $error("fired_id: expected %0d got %0d", e.fired_id, out_item.fired_id);
          errors++;
        end
        if (out_item.last !== e.last) begin
          $error("last: expected %0d got %0d", e.last, out_item.last);
          errors++;
        end
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk) begin
    int mode_sel;
    mode_sel = $urandom_range(0, 3);
    if (hold_long) out_stall <= 1'b1;
    else if (mode_sel == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 30);
  end

  // watchdog: cycles with nothing accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // send one item: hold valid until accepted, then predict
  task automatic send_item(pat_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    predict_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_step(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    step = (v == 0) ? 16'd1 : v;
  endtask

  function automatic pat_pkg::in_item_t mk(logic [1:0] m, logic [15:0] id,
                                           logic [31:0] p, logic [31:0] f);
    pat_pkg::in_item_t it;
    it.mode = m; it.alarm_id = id; it.period = p; it.first_call = f;
    return it;
  endfunction

  // random item; mostly well-formed, with ids from a small pool
  function automatic pat_pkg::in_item_t rand_item();
    pat_pkg::in_item_t it;
    int k;
    int s;
    k = $urandom_range(0, 99);
    it = mk(pat_pkg::MODE_TICK, 16'($urandom), $urandom, $urandom);
    if (k < 45) begin
      it.mode = pat_pkg::MODE_TICK;
    end else if (k < 75) begin
      it.mode = pat_pkg::MODE_REG;
      it.alarm_id = 16'($urandom_range(1, 6));
      it.period = $urandom_range(0, 8 * step);
      it.first_call = $urandom_range(0, 4 * step);
      if ($urandom_range(0, 9) == 0) it.alarm_id = 16'($urandom);
      if ($urandom_range(0, 9) == 0) it.period = $urandom;
      if ($urandom_range(0, 9) == 0) it.first_call = $urandom;
    end else if (k < 95) begin
      it.mode = pat_pkg::MODE_REM;
      s = $urandom_range(0, NSLOT - 1);
      if (a_id[s] != 0 && $urandom_range(0, 3) != 0) begin
        it.alarm_id = a_id[s]; it.period = a_per[s]; it.first_call = a_first[s];
      end else begin
        it.alarm_id = 16'($urandom_range(0, 6));
        it.period = $urandom_range(0, 8) * step;
        it.first_call = $urandom_range(0, 4) * step;
      end
    end else begin
      it.mode = 2'd3;
    end
    return it;
  endfunction

  // directed table; expected status typed where obvious (ST_OK == don't care
  // on tick rows, always predictor checked)
  typedef struct {
    pat_pkg::in_item_t it;
    logic [1:0] st;
  } row_t;

  row_t dir_rows[$];
  row_t rw;
  int burst;
  int n_sent;

  initial begin
    step = pat_pkg::STEP_RESET;
    now_t = '0;
    for (int i = 0; i < NSLOT; i++) begin
      a_id[i] = '0; a_per[i] = '0; a_first[i] = '0; a_due[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: bad params, extremes, unknown mode, match, not found
    dir_rows.push_back('{mk(pat_pkg::MODE_TICK, 16'd0, 32'd0, 32'd0), pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_REG, 16'd0, 32'd100, 32'd0), pat_pkg::ST_BAD});
    dir_rows.push_back('{mk(pat_pkg::MODE_REG, 16'd5, 32'h8000_0000, 32'd0),
                         pat_pkg::ST_BAD});
    dir_rows.push_back('{mk(pat_pkg::MODE_REG, 16'd5, 32'd0, 32'hFFFF_FFFF),
                         pat_pkg::ST_BAD});
    dir_rows.push_back('{mk(2'd3, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                         pat_pkg::ST_BAD});
    dir_rows.push_back('{mk(pat_pkg::MODE_REG, 16'hFFFF, 32'd150, 32'd99), pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_REG, 16'd1, 32'd100, 32'd0), pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_REG, 16'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
                         pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_REG, 16'd3, 32'd0, 32'd0), pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_TICK, 16'd0, 32'd0, 32'd0), pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_TICK, 16'd0, 32'd0, 32'd0), pat_pkg::ST_OK});
    // rounded past 2^31: the same bits as a negative request must not match
    dir_rows.push_back('{mk(pat_pkg::MODE_REM, 16'd2, 32'h8000_0034, 32'h8000_0034),
                         pat_pkg::ST_NOTFOUND});
    dir_rows.push_back('{mk(pat_pkg::MODE_REM, 16'hFFFF, 32'd150, 32'd0),
                         pat_pkg::ST_NOTFOUND});
    dir_rows.push_back('{mk(pat_pkg::MODE_REM, 16'hFFFF, 32'd200, 32'd0), pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_REM, 16'd0, 32'd0, 32'd0), pat_pkg::ST_NOTFOUND});
    dir_rows.push_back('{mk(pat_pkg::MODE_REM, 16'd3, 32'd0, 32'd0), pat_pkg::ST_OK});
    dir_rows.push_back('{mk(pat_pkg::MODE_TICK, 16'd0, 32'd0, 32'd0), pat_pkg::ST_OK});
    foreach (dir_rows[j]) begin
      rw = dir_rows[j];
      send_item(rw.it);
      if (rw.it.mode != pat_pkg::MODE_TICK && expected_q[$].status != rw.st) begin
        $error("status: expected %0d got %0d (directed row %0d)", rw.st,
               expected_q[$].status, j);
        errors++;
      end
    end
    drain();

    // fill the table to full, one extra register, then many firings per tick
    write_step(16'd1);
    for (int i = 0; i < NSLOT + 1; i++)
      send_item(mk(pat_pkg::MODE_REG, 16'(100 + i), 32'd1, 32'd0));
    for (int i = 0; i < 4; i++) send_item(mk(pat_pkg::MODE_TICK, '0, '0, '0));
    // long receiver hold-off while items keep coming
    hold_long = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      for (int i = 0; i < 4; i++) send_item(mk(pat_pkg::MODE_TICK, '0, '0, '0));
    join
    for (int i = 0; i < NSLOT; i++)
      send_item(mk(pat_pkg::MODE_REM, 16'(100 + i), 32'd1, 32'd0));
    drain();

    // random phases across several step settings
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_step(16'd100);
        1: write_step(16'hFFFF);
        2: write_step(16'd0);
        default: write_step(16'd7);
      endcase
      n_sent = 0;
      while (n_sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n_sent < PHASE_ITEMS; b++) begin
          send_item(rand_item());
          n_sent++;
        end
        if ($urandom_range(0, 2) == 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
      end
      drain();
      // clear the table between phases so the next step starts fresh
      for (int i = 0; i < NSLOT; i++)
        if (a_id[i] != 0)
          send_item(mk(pat_pkg::MODE_REM, a_id[i], a_per[i], a_first[i]));
      drain();
    end

    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/pat_pkg.sv
rtl/pat_datapath.sv
rtl/pat_ctrl.sv
rtl/periodic_alarm_table.sv
sim/periodic_alarm_table_test.sv
